// ----- hw/rtl/wrtc_pkg.sv -----
// Shared constants, types and functions for the weather report token classifier.
package wrtc_pkg;

	localparam int unsigned NUM_PAT    = 16;
	localparam int unsigned MAX_LEN    = 5;
	localparam int unsigned HIST_DEPTH = MAX_LEN - 1;
	localparam int unsigned MARK_W     = 9;

	localparam logic [7:0] CHAR_Z = 8'h5A;

	// mark bit positions
	localparam int unsigned MARK_TS     = 0;
	localparam int unsigned MARK_SN     = 1;
	localparam int unsigned MARK_SH     = 2;
	localparam int unsigned MARK_RA     = 3;
	localparam int unsigned MARK_DZ     = 4;
	localparam int unsigned MARK_FOG    = 5;
	localparam int unsigned MARK_CLOUDY = 6;
	localparam int unsigned MARK_SCT    = 7;
	localparam int unsigned MARK_CLEAR  = 8;

	typedef logic [NUM_PAT-1:0] pat_vec_t;
	typedef logic [MARK_W-1:0]  mark_vec_t;

	typedef enum logic [3:0] {
		COND_CLEAR   = 4'd0,
		COND_PARTLY  = 4'd1,
		COND_CLOUDY  = 4'd2,
		COND_FOG     = 4'd3,
		COND_DRIZZLE = 4'd4,
		COND_RAIN    = 4'd5,
		COND_SHOWERS = 4'd6,
		COND_SNOW    = 4'd7,
		COND_THUNDER = 4'd8
	} cond_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	// Pattern text, newest character first: [p][0] is the final character,
	// [p][k] the one k bytes earlier. Unused slots are zero.
	localparam logic [7:0] PAT_CHR [NUM_PAT][MAX_LEN] = '{
		'{"S", "T", 8'h00, 8'h00, 8'h00},  // TS
		'{"N", "S", 8'h00, 8'h00, 8'h00},  // SN
		'{"H", "S", 8'h00, 8'h00, 8'h00},  // SH
		'{"A", "R", 8'h00, 8'h00, 8'h00},  // RA
		'{"Z", "D", 8'h00, 8'h00, 8'h00},  // DZ
		'{"G", "F", " ",   8'h00, 8'h00},  // " FG"
		'{"G", "F", "C",   "B",   8'h00},  // BCFG
		'{"R", "B", " ",   8'h00, 8'h00},  // " BR"
		'{"C", "V", "O",   8'h00, 8'h00},  // OVC
		'{"N", "K", "B",   8'h00, 8'h00},  // BKN
		'{"T", "C", "S",   8'h00, 8'h00},  // SCT
		'{"K", "O", "V",   "A",   "C"  },  // CAVOK
		'{"R", "L", "C",   8'h00, 8'h00},  // CLR
		'{"C", "K", "S",   8'h00, 8'h00},  // SKC
		'{"C", "S", "N",   8'h00, 8'h00},  // NSC
		'{"W", "E", "F",   8'h00, 8'h00}   // FEW
	};

	localparam logic [2:0] PAT_LEN [NUM_PAT] = '{
		3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd4, 3'd3,
		3'd3, 3'd3, 3'd3, 3'd5, 3'd3, 3'd3, 3'd3, 3'd3
	};

	localparam logic [3:0] PAT_MARK [NUM_PAT] = '{
		4'(MARK_TS), 4'(MARK_SN), 4'(MARK_SH), 4'(MARK_RA),
		4'(MARK_DZ), 4'(MARK_FOG), 4'(MARK_FOG), 4'(MARK_FOG),
		4'(MARK_CLOUDY), 4'(MARK_CLOUDY), 4'(MARK_SCT), 4'(MARK_CLEAR),
		4'(MARK_CLEAR), 4'(MARK_CLEAR), 4'(MARK_CLEAR), 4'(MARK_CLEAR)
	};

	// Priority: thunder down to clear; partly when nothing was seen.
	function automatic cond_t encode_marks(input mark_vec_t m);
		cond_t c;
		if (m[MARK_TS])          c = COND_THUNDER;
		else if (m[MARK_SN])     c = COND_SNOW;
		else if (m[MARK_SH])     c = COND_SHOWERS;
		else if (m[MARK_RA])     c = COND_RAIN;
		else if (m[MARK_DZ])     c = COND_DRIZZLE;
		else if (m[MARK_FOG])    c = COND_FOG;
		else if (m[MARK_CLOUDY]) c = COND_CLOUDY;
		else if (m[MARK_SCT])    c = COND_PARTLY;
		else if (m[MARK_CLEAR])  c = COND_CLEAR;
		else                     c = COND_PARTLY;
		return c;
	endfunction

endpackage

// ----- hw/rtl/wrtc_in_if.sv -----
// Input channel: one report byte per word, with a last-byte mark.
interface wrtc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] report_byte;
	logic       last_byte;

	modport source (output valid, output report_byte, output last_byte, input ready);
	modport sink   (input valid, input report_byte, input last_byte, output ready);
endinterface

// ----- hw/rtl/wrtc_out_if.sv -----
// Output channel: one condition code per word.
interface wrtc_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] condition;

	modport source (output valid, output condition, input ready);
	modport sink   (input valid, input condition, output ready);
endinterface

// ----- hw/rtl/wrtc_cell.sv -----
// History cell: holds one past byte, shifts it on, and qualifies pattern hits.
module wrtc_cell #(
	parameter int unsigned OFFSET = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wrtc_pkg::cell_ctrl_t ctrl,
	input  logic [7:0]         byte_in,
	input  wrtc_pkg::pat_vec_t hit_in,
	output logic [7:0]         byte_out,
	output wrtc_pkg::pat_vec_t hit_out
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'h00;
		end else if (ctrl.clear) begin
			byte_q <= 8'h00;
		end else if (ctrl.shift) begin
			byte_q <= byte_in;
		end
	end

	// A pattern no longer than this offset does not look at this cell.
	always_comb begin
		for (int p = 0; p < wrtc_pkg::NUM_PAT; p++) begin
			hit_out[p] = hit_in[p] &
				((3'(OFFSET) >= wrtc_pkg::PAT_LEN[p]) ||
				 (byte_q == wrtc_pkg::PAT_CHR[p][OFFSET]));
		end
	end

	assign byte_out = byte_q;

endmodule

// ----- hw/rtl/weather_report_token_classifier.sv -----
// Top level of the weather report token classifier.
//
// Usage:
//   rpt carries report text, one byte per word; last_byte marks the final
//   byte of a report. cnd carries one condition code per report
//   (0 clear .. 8 thunder), sent after the final byte is taken.
//   Text up to and including the first 'Z' (time group) is ignored; with
//   no 'Z' the whole report is searched.
//   Throughput: one byte per cycle, reports back to back, if cnd drains.
//   The code is on cnd in the cycle after the final byte is taken.
//   The search runs through four history cells, one byte each, compared
//   combinationally; first 'Z' and last byte clear them, others shift.
//   Stall: a single output register holds the code; rpt.ready stays high
//   while that register is empty or being drained, so the block stops
//   taking bytes only when a code is waiting and cnd.ready is low.
//   Reset: arst_n clears history, marks, time group flag and the output
//   valid flag; the block is ready once reset is released.
//   After each final byte history, marks and flag return to that state.
module weather_report_token_classifier (
	input  logic        clk,
	input  logic        arst_n,
	wrtc_in_if.sink     rpt,
	wrtc_out_if.source  cnd
);

	localparam int unsigned DEPTH = wrtc_pkg::HIST_DEPTH;

	logic                  acc;
	logic                  first_z;
	logic                  tg_q;
	wrtc_pkg::mark_vec_t   marks_q;
	wrtc_pkg::mark_vec_t   marks_set;
	wrtc_pkg::mark_vec_t   marks_next;
	wrtc_pkg::cell_ctrl_t  cell_ctrl;
	wrtc_pkg::pat_vec_t    hit_chain  [DEPTH+1];
	logic [7:0]            byte_chain [DEPTH+1];
	logic                  cvalid_q;
	wrtc_pkg::cond_t       cond_q;

	assign acc       = rpt.valid && rpt.ready;
	assign rpt.ready = !cvalid_q || cnd.ready;

	// first 'Z' ends the time group; later ones are plain text
	assign first_z = !tg_q && (rpt.report_byte == wrtc_pkg::CHAR_Z);

	// clear wins over shift inside each cell
	assign cell_ctrl.shift = acc && !first_z;
	assign cell_ctrl.clear = acc && (first_z || rpt.last_byte);

	// offset 0: current byte against each pattern's final character
	always_comb begin
		for (int p = 0; p < wrtc_pkg::NUM_PAT; p++) begin
			hit_chain[0][p] = (rpt.report_byte == wrtc_pkg::PAT_CHR[p][0]);
		end
	end
	assign byte_chain[0] = rpt.report_byte;

	for (genvar k = 1; k <= DEPTH; k++) begin : g_cell
		wrtc_cell #(
			.OFFSET (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl),
			.byte_in  (byte_chain[k-1]),
			.hit_in   (hit_chain[k-1]),
			.byte_out (byte_chain[k]),
			.hit_out  (hit_chain[k])
		);
	end

	// fold full-pattern matches onto their class marks
	always_comb begin
		marks_set = '0;
		for (int p = 0; p < wrtc_pkg::NUM_PAT; p++) begin
			if (hit_chain[DEPTH][p]) begin
				marks_set[wrtc_pkg::PAT_MARK[p]] = 1'b1;
			end
		end
		marks_next = first_z ? '0 : (marks_q | marks_set);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tg_q    <= 1'b0;
			marks_q <= '0;
		end else if (acc) begin
			if (rpt.last_byte) begin
				tg_q    <= 1'b0;
				marks_q <= '0;
			end else begin
				tg_q    <= tg_q | first_z;
				marks_q <= marks_next;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvalid_q <= 1'b0;
		end else if (acc && rpt.last_byte) begin
			cvalid_q <= 1'b1;
		end else if (cnd.ready) begin
			cvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && rpt.last_byte) begin
			cond_q <= wrtc_pkg::encode_marks(marks_next);
		end
	end

	assign cnd.valid     = cvalid_q;
	assign cnd.condition = cond_q;

`ifndef ASSERT_OFF
	// end of report puts the search state back to reset
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && rpt.last_byte |=> !tg_q && (marks_q == '0))
		else $error("state not cleared after final byte");

	// first Z mid-report opens the search with no marks
	a_first_z: assert property (@(posedge clk) disable iff (!arst_n)
		acc && first_z && !rpt.last_byte |=> tg_q && (marks_q == '0))
		else $error("first Z did not restart the search");

	// every final byte yields a pending code
	a_code_out: assert property (@(posedge clk) disable iff (!arst_n)
		acc && rpt.last_byte |=> cnd.valid)
		else $error("no code after final byte");
`endif

endmodule
